/* rtl/der_signature_canonical_check_macros.svh */
// Assertion macros shared by the checker RTL.
// Each macro expects a clock named clk_i and an active-low reset named rst_ni.
`ifndef DER_SIGNATURE_CANONICAL_CHECK_MACROS_SVH
`define DER_SIGNATURE_CANONICAL_CHECK_MACROS_SVH

// Check a property on every rising edge, ignored while reset is asserted
`define DSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, including during reset
`define DSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/dsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Types, constants and codes for the strict DER signature encoding checker.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Encoding constants
  localparam logic [7:0] SEQ_TAG  = 8'h30;
  localparam logic [7:0] INT_TAG  = 8'h02;
  localparam logic [7:0] SIGN_BIT = 8'h80;

  // Signature size limits, in bytes
  localparam int unsigned MAX_SIG_BYTES = 73;
  localparam int unsigned MIN_SIG_BYTES = 9;

  // Byte counter saturates at its top value
  localparam int unsigned CNT_W     = 7;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register file
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HT_LOW  = 2'd0,
    CFG_HT_HIGH = 2'd1,
    CFG_HT_MASK = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] HT_LOW_RST  = 8'd1;
  localparam logic [7:0] HT_HIGH_RST = 8'd3;
  localparam logic [7:0] HT_MASK_RST = 8'd128;

  // Verdict codes, first failing check wins
  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_SHORT       = 4'd1,
    ERR_LONG        = 4'd2,
    ERR_HASHTYPE    = 4'd3,
    ERR_TYPE        = 4'd4,
    ERR_LENGTH      = 4'd5,
    ERR_S_PLACE     = 4'd6,
    ERR_SUM         = 4'd7,
    ERR_R_TAG       = 4'd8,
    ERR_R_ZERO      = 4'd9,
    ERR_R_NEGATIVE  = 4'd10,
    ERR_R_PADDED    = 4'd11,
    ERR_S_TAG       = 4'd12,
    ERR_S_ZERO      = 4'd13,
    ERR_S_NEGATIVE  = 4'd14,
    ERR_S_PADDED    = 4'd15
  } err_code_e;

  // Captured fields of one complete signature, handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] size;
    logic [7:0]       hash_byte;
    logic [7:0]       header_type;
    logic [7:0]       length_marker;
    logic [7:0]       r_tag;
    logic [7:0]       r_length;
    logic [7:0]       r_first;
    logic [7:0]       r_second;
    logic [7:0]       s_tag;
    logic [7:0]       s_length;
    logic [7:0]       s_first;
    logic [7:0]       s_second;
  } sig_rec_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/dsc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_if
// Valid/ready channels: signature bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface dsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] sig_byte;
  logic       last_byte;

  modport source (output valid, output sig_byte, output last_byte, input ready);
  modport sink   (input valid, input sig_byte, input last_byte, output ready);
endinterface

interface dsc_verdict_if;
  logic       valid;
  logic       ready;
  logic       is_canonical;
  logic [3:0] error_code;

  modport source (output valid, output is_canonical, output error_code, input ready);
  modport sink   (input valid, input is_canonical, input error_code, output ready);
endinterface

/* rtl/der_signature_canonical_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// der_signature_canonical_check
// Strict DER signature encoding check, one verdict per signature.
// ----------------------------------------------------------------------------
// Usage:
//   sig_if carries the signature one byte per transfer; last_byte marks the
//   final byte, which is the hash-type byte. res_if carries one verdict per
//   signature: error_code (0 when canonical, else the first failing check)
//   and is_canonical.
//   Throughput is one byte per cycle, back to back, across signatures, while the queue is not full.
//   From the transfer of the last byte, a verdict passes through the queue
//   register and then through the check logic into the output register.
//   The byte counter saturates; a signature longer than the limit reports
//   too long and no bytes beyond the saturation point are captured.
//   When res_if stalls, verdicts wait in the output register and the queue;
//   sig_if keeps taking bytes until the queue is full.
//   Reset empties the queue, clears the capture state and restores the
//   hash-type registers to low 1, high 3 and flag mask 0x80.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i,
//   by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module der_signature_canonical_check
  import dsc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dsc_byte_if.sink              sig_if,
  dsc_verdict_if.source         res_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  q_status_t q_status;
  logic      push, pop;
  sig_rec_t  push_rec, pop_rec;

  // Count and capture bytes
  dsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sig_if     (sig_if),
    .q_status_i (q_status),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  // Decouple capture from checking
  dsc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .status_o   (q_status)
  );

  // Check and deliver verdicts
  dsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rec_i      (pop_rec),
    .q_status_i (q_status),
    .pop_o      (pop),
    .res_if     (res_if)
  );

endmodule

/* rtl/dsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_front
// Counts signature bytes and captures the ones the checks need by position.
// ----------------------------------------------------------------------------
module dsc_front
  import dsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dsc_byte_if.sink    sig_if,
  input  q_status_t   q_status_i,
  output logic        push_o,
  output sig_rec_t    rec_o
);

  `include "der_signature_canonical_check_macros.svh"

  logic [CNT_W-1:0] count_q, count_d;
  sig_rec_t         cap_q, cap_d;
  logic             acc;
  logic             in_range;
  logic [8:0]       pos9;
  logic [8:0]       rl9;

  // Take bytes whenever the queue can hold a finished signature
  assign sig_if.ready = !q_status_i.full;
  assign acc          = sig_if.valid && sig_if.ready;
  assign in_range     = (count_q != CNT_SAT);
  assign pos9         = {2'b00, count_q};
  assign rl9          = {1'b0, cap_q.r_length};

  // Capture bytes by position; S slots follow the R length seen so far
  always_comb begin
    cap_d = cap_q;
    if (in_range) begin
      if (count_q == CNT_W'(0)) cap_d.header_type   = sig_if.sig_byte;
      if (count_q == CNT_W'(1)) cap_d.length_marker = sig_if.sig_byte;
      if (count_q == CNT_W'(2)) cap_d.r_tag         = sig_if.sig_byte;
      if (count_q == CNT_W'(3)) cap_d.r_length      = sig_if.sig_byte;
      if (count_q == CNT_W'(4)) cap_d.r_first       = sig_if.sig_byte;
      if (count_q == CNT_W'(5)) cap_d.r_second      = sig_if.sig_byte;
      if (count_q >= CNT_W'(4)) begin
        if (pos9 == rl9 + 9'd4) cap_d.s_tag    = sig_if.sig_byte;
        if (pos9 == rl9 + 9'd5) cap_d.s_length = sig_if.sig_byte;
        if (pos9 == rl9 + 9'd6) cap_d.s_first  = sig_if.sig_byte;
        if (pos9 == rl9 + 9'd7) cap_d.s_second = sig_if.sig_byte;
      end
    end
  end

  // Advance the saturating byte counter
  always_comb begin
    count_d = in_range ? count_q + CNT_W'(1) : count_q;
  end

  // Hand the finished signature to the queue on its last byte
  always_comb begin
    rec_o           = cap_d;
    rec_o.size      = count_d;
    rec_o.hash_byte = sig_if.sig_byte;
    push_o          = acc && sig_if.last_byte;
  end

  // Hold capture state; clear it once a signature is complete
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= '0;
    end else if (acc) begin
      if (sig_if.last_byte) begin
        count_q <= '0;
        cap_q   <= '0;
      end else begin
        count_q <= count_d;
        cap_q   <= cap_d;
      end
    end
  end

  `DSC_ASSERT(a_front_clear, acc && sig_if.last_byte |=> count_q == '0, "count not cleared")
  `DSC_ASSERT(a_front_sat, count_q == CNT_SAT && acc && !sig_if.last_byte |=> count_q == CNT_SAT, "count left saturation")

endmodule

/* rtl/dsc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_queue
// Short register queue of captured signatures between front and back.
// ----------------------------------------------------------------------------
module dsc_queue
  import dsc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sig_rec_t  push_rec_i,
  input  logic      pop_i,
  output sig_rec_t  pop_rec_o,
  output q_status_t status_o
);

  `include "der_signature_canonical_check_macros.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  sig_rec_t          mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign status_o.full  = (fill_q == CNT_FULL);
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_rec_o      = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    if (do_push && !do_pop) fill_d = fill_q + CNT_QW'(1);
    if (do_pop && !do_push) fill_d = fill_q - CNT_QW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_rec_i;
  end

  `DSC_ASSERT(a_queue_no_overflow, !(push_i && status_o.full), "push into full queue")
  `DSC_ASSERT_ALWAYS(a_queue_fill, fill_q <= CNT_FULL, "fill level beyond depth")

endmodule

/* rtl/dsc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_back
// Runs the ordered checks on a captured signature and registers the verdict.
// ----------------------------------------------------------------------------
module dsc_back
  import dsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  sig_rec_t              rec_i,
  input  q_status_t             q_status_i,
  output logic                  pop_o,
  dsc_verdict_if.source         res_if
);

  `include "der_signature_canonical_check_macros.svh"

  logic [7:0] ht_low_q, ht_high_q, ht_mask_q;
  logic       out_valid_q;
  err_code_e  code_q, code_d;
  logic [7:0] ht;
  logic [7:0] size8;
  logic [8:0] rl9, sl9;
  logic [9:0] sum10;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ht_low_q  <= HT_LOW_RST;
      ht_high_q <= HT_HIGH_RST;
      ht_mask_q <= HT_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HT_LOW:  ht_low_q  <= cfg_data_i;
        CFG_HT_HIGH: ht_high_q <= cfg_data_i;
        CFG_HT_MASK: ht_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ht    = rec_i.hash_byte & ~ht_mask_q;
  assign size8 = {1'b0, rec_i.size};
  assign rl9   = {1'b0, rec_i.r_length};
  assign sl9   = {1'b0, rec_i.s_length};
  assign sum10 = {1'b0, rl9} + {1'b0, sl9} + 10'd7;

  // Pick the first failing check
  always_comb begin
    priority if (size8 < 8'(MIN_SIG_BYTES))                 code_d = ERR_SHORT;
    else if (size8 > 8'(MAX_SIG_BYTES))                     code_d = ERR_LONG;
    else if (ht < ht_low_q || ht > ht_high_q)               code_d = ERR_HASHTYPE;
    else if (rec_i.header_type != SEQ_TAG)                  code_d = ERR_TYPE;
    else if (rec_i.length_marker != size8 - 8'd3)           code_d = ERR_LENGTH;
    else if (rl9 + 9'd5 >= {1'b0, size8})                   code_d = ERR_S_PLACE;
    else if (sum10 != {2'b00, size8})                       code_d = ERR_SUM;
    else if (rec_i.r_tag != INT_TAG)                        code_d = ERR_R_TAG;
    else if (rec_i.r_length == 8'd0)                        code_d = ERR_R_ZERO;
    else if ((rec_i.r_first & SIGN_BIT) != 8'd0)            code_d = ERR_R_NEGATIVE;
    else if (rec_i.r_length > 8'd1 && rec_i.r_first == 8'd0
             && (rec_i.r_second & SIGN_BIT) == 8'd0)        code_d = ERR_R_PADDED;
    else if (rec_i.s_tag != INT_TAG)                        code_d = ERR_S_TAG;
    else if (rec_i.s_length == 8'd0)                        code_d = ERR_S_ZERO;
    else if ((rec_i.s_first & SIGN_BIT) != 8'd0)            code_d = ERR_S_NEGATIVE;
    else if (rec_i.s_length > 8'd1 && rec_i.s_first == 8'd0
             && (rec_i.s_second & SIGN_BIT) == 8'd0)        code_d = ERR_S_PADDED;
    else                                                    code_d = ERR_NONE;
  end

  // Pop when the output register is free or being drained
  assign pop_o = !q_status_i.empty && (!out_valid_q || res_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_if.ready) begin
      out_valid_q <= !q_status_i.empty;
    end
  end

  // Verdict payload, loaded on each pop
  always_ff @(posedge clk_i) begin
    if (pop_o) code_q <= code_d;
  end

  assign res_if.valid        = out_valid_q;
  assign res_if.error_code   = code_q;
  assign res_if.is_canonical = (code_q == ERR_NONE);

  `DSC_ASSERT(a_back_load, $rose(out_valid_q) |-> $past(pop_o), "verdict shown without a pop")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams signatures byte by byte into the strict DER encoding checker and
// compares every verdict with an in-bench prediction of the first failing
// check. Both channels stall at random outside the no-idling phases; the
// hash-type registers are changed between phases while the checker is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import dsc_pkg::*;

  localparam int unsigned RESET_CYCLES     = 5;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned TAIL_CYCLES      = 20;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned PHASE_BYTES      = 310;
  localparam int unsigned NUM_PHASES       = 6;
  localparam int unsigned LONG_HOLD_AT     = 12;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  // Hash-type register settings per random phase: low, high, flag mask
  localparam logic [7:0] PH_LOW  [NUM_PHASES] = '{8'd1,   8'd0,   8'd255, 8'h81, 8'd0,   8'd1};
  localparam logic [7:0] PH_HIGH [NUM_PHASES] = '{8'd3,   8'd255, 8'd0,   8'h83, 8'd0,   8'd3};
  localparam logic [7:0] PH_MASK [NUM_PHASES] = '{8'h80,  8'h00,  8'hFF,  8'h00, 8'hFF,  8'h80};

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic      canonical;
    err_code_e code;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  dsc_byte_if    sig_if ();
  dsc_verdict_if res_if ();

  der_signature_canonical_check i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sig_if     (sig_if),
    .res_if     (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Bytes waiting for the driver, verdicts waiting for the checker output
  stream_byte_t byte_q[$];
  verdict_t     verdict_q[$];
  logic [7:0]   sig_buf[$];

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 52;
  int unsigned mismatch_cnt  = 0;
  int unsigned queued_bytes  = 0;
  int unsigned cycle_cnt     = 0;

  // Copy of the hash-type registers
  logic [7:0] ht_low_cfg  = HT_LOW_RST;
  logic [7:0] ht_high_cfg = HT_HIGH_RST;
  logic [7:0] ht_mask_cfg = HT_MASK_RST;

  // Captured header fields of the signature in flight
  logic [CNT_W-1:0] seen_cnt = '0;
  logic [7:0] cap_type = '0, cap_len = '0, cap_rtag = '0, cap_rlen = '0;
  logic [7:0] cap_r0 = '0, cap_r1 = '0, cap_stag = '0, cap_slen = '0;
  logic [7:0] cap_s0 = '0, cap_s1 = '0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // First failing check of a complete signature of the given size
  function automatic err_code_e judge_sig(input int unsigned size, input logic [7:0] hash_byte);
    logic [7:0]  ht;
    int unsigned rl;
    int unsigned sl;
    ht = hash_byte & ~ht_mask_cfg;
    rl = cap_rlen;
    sl = cap_slen;
    if (size < MIN_SIG_BYTES) return ERR_SHORT;
    if (size > MAX_SIG_BYTES) return ERR_LONG;
    if (ht < ht_low_cfg || ht > ht_high_cfg) return ERR_HASHTYPE;
    if (cap_type != SEQ_TAG) return ERR_TYPE;
    if (cap_len != size - 3) return ERR_LENGTH;
    if (5 + rl >= size) return ERR_S_PLACE;
    if (rl + sl + 7 != size) return ERR_SUM;
    if (cap_rtag != INT_TAG) return ERR_R_TAG;
    if (rl == 0) return ERR_R_ZERO;
    if ((cap_r0 & SIGN_BIT) != 0) return ERR_R_NEGATIVE;
    if (rl > 1 && cap_r0 == 8'h00 && (cap_r1 & SIGN_BIT) == 0) return ERR_R_PADDED;
    if (cap_stag != INT_TAG) return ERR_S_TAG;
    if (sl == 0) return ERR_S_ZERO;
    if ((cap_s0 & SIGN_BIT) != 0) return ERR_S_NEGATIVE;
    if (sl > 1 && cap_s0 == 8'h00 && (cap_s1 & SIGN_BIT) == 0) return ERR_S_PADDED;
    return ERR_NONE;
  endfunction

  // Capture one accepted byte by position; on the final byte queue the verdict
  task automatic absorb_byte(input logic [7:0] b, input logic is_last);
    int unsigned pos;
    int unsigned rl;
    err_code_e   code;
    verdict_t    v;
    pos = seen_cnt;
    rl  = cap_rlen;
    if (pos < CNT_SAT) begin
      if (pos == 0) cap_type = b;
      if (pos == 1) cap_len  = b;
      if (pos == 2) cap_rtag = b;
      if (pos == 3) cap_rlen = b;
      if (pos == 4) cap_r0   = b;
      if (pos == 5) cap_r1   = b;
      if (pos >= 4) begin
        if (pos == 4 + rl) cap_stag = b;
        if (pos == 5 + rl) cap_slen = b;
        if (pos == 6 + rl) cap_s0   = b;
        if (pos == 7 + rl) cap_s1   = b;
      end
      seen_cnt = seen_cnt + 1'b1;
    end
    if (is_last) begin
      code        = judge_sig(seen_cnt, b);
      v.code      = code;
      v.canonical = (code == ERR_NONE);
      verdict_q.insert(verdict_q.size(), v);
      seen_cnt = '0;
      cap_type = '0; cap_len = '0; cap_rtag = '0; cap_rlen = '0; cap_r0 = '0;
      cap_r1 = '0; cap_stag = '0; cap_slen = '0; cap_s0 = '0; cap_s1 = '0;
    end
  endtask

  // Input driver: offer the next pending byte, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_if.valid     <= 1'b0;
      sig_if.sig_byte  <= '0;
      sig_if.last_byte <= 1'b0;
    end else if (!sig_if.valid || sig_if.ready) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sig_if.valid     <= 1'b1;
        sig_if.sig_byte  <= byte_q[0].value;
        sig_if.last_byte <= byte_q[0].last;
        void'(byte_q.pop_front());
      end else begin
        sig_if.valid <= 1'b0;
      end
    end
  end

  // Input monitor: predict on every byte transfer
  always @(posedge clk_i) begin
    if (rst_ni && sig_if.valid && sig_if.ready) begin
      absorb_byte(sig_if.sig_byte, sig_if.last_byte);
    end
  end

  // Output monitor and receiver: check verdicts, drive ready with one long hold
  int unsigned verdicts_seen  = 0;
  int unsigned hold_left      = 0;
  logic        long_hold_done = 1'b0;
  verdict_t    oldest_verdict;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict: expected none, actual canonical %0b code %0d",
                   $time, res_if.is_canonical, res_if.error_code);
          mismatch_cnt++;
        end else begin
          oldest_verdict = verdict_q.pop_front();
          if (res_if.is_canonical !== oldest_verdict.canonical) begin
            $display("%0t: is_canonical mismatch: expected %0b actual %0b",
                     $time, oldest_verdict.canonical, res_if.is_canonical);
            mismatch_cnt++;
          end
          if (res_if.error_code !== oldest_verdict.code) begin
            $display("%0t: error_code mismatch: expected %0d actual %0d",
                     $time, oldest_verdict.code, res_if.error_code);
            mismatch_cnt++;
          end
        end
        verdicts_seen++;
      end
      if (!long_hold_done && verdicts_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Move the scratch signature into the driver queue, final byte flagged
  task automatic flush_sig();
    stream_byte_t sb;
    for (int i = 0; i < sig_buf.size(); i++) begin
      sb.value = sig_buf[i];
      sb.last  = (i == sig_buf.size() - 1);
      byte_q.insert(byte_q.size(), sb);
    end
    queued_bytes += sig_buf.size();
    sig_buf.delete();
  endtask

  // Append one byte to the scratch signature
  task automatic append_sig_byte(input logic [7:0] b);
    sig_buf.insert(sig_buf.size(), b);
  endtask

  // Integer length, mostly short, sometimes zero
  function automatic int unsigned pick_int_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 33);
  endfunction

  // Integer content with the sign and padding cases in the first two bytes
  task automatic add_int_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) begin
        case ($urandom_range(3))
          0:       append_sig_byte(8'h00);
          1:       append_sig_byte(8'($urandom_range(128, 255)));
          default: append_sig_byte(8'($urandom_range(1, 127)));
        endcase
      end else begin
        append_sig_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Well-formed signature with random content, sometimes with one field broken
  task automatic make_wellformed();
    int unsigned rl;
    int unsigned sl;
    int unsigned r;
    logic [7:0]  ht;
    rl = pick_int_len();
    sl = pick_int_len();
    r  = $urandom_range(99);
    if (r < 3) begin
      rl = 33;
      sl = 33;
    end else if (r < 5) begin
      rl = 33;
      sl = 34;
    end
    if ($urandom_range(99) < 70 && ht_low_cfg <= ht_high_cfg) begin
      ht = 8'($urandom_range(ht_low_cfg, ht_high_cfg)) | (ht_mask_cfg & 8'($urandom_range(255)));
    end else begin
      ht = 8'($urandom_range(255));
    end
    sig_buf.delete();
    append_sig_byte(SEQ_TAG);
    append_sig_byte(8'(rl + sl + 4));
    append_sig_byte(INT_TAG);
    append_sig_byte(8'(rl));
    add_int_bytes(rl);
    append_sig_byte(INT_TAG);
    append_sig_byte(8'(sl));
    add_int_bytes(sl);
    append_sig_byte(ht);
    // Break one field in about a third of the signatures
    if ($urandom_range(99) < 35) begin
      case ($urandom_range(9))
        0: sig_buf[0] = 8'($urandom_range(255));
        1: sig_buf[1] = $urandom_range(1) ? sig_buf[1] + 8'd1 : sig_buf[1] - 8'd1;
        2: sig_buf[2] = 8'($urandom_range(255));
        3: sig_buf[3] = 8'($urandom_range(0, rl + sl + 4));
        4: sig_buf[4 + rl] = 8'($urandom_range(255));
        5: sig_buf[5 + rl] = 8'($urandom_range(0, sl + 3));
        6: sig_buf.delete($urandom_range(0, sig_buf.size() - 2));
        7: sig_buf.insert($urandom_range(0, sig_buf.size() - 1), 8'($urandom_range(255)));
        default: sig_buf[sig_buf.size() - 1] = 8'($urandom_range(255));
      endcase
    end
    flush_sig();
  endtask

  // Random bytes of random length, occasionally past counter saturation
  task automatic make_noise();
    int unsigned n;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) n = $urandom_range(1, 12);
    else if (r < 90) n = $urandom_range(13, 73);
    else n = $urandom_range(74, 140);
    sig_buf.delete();
    for (int unsigned i = 0; i < n; i++) append_sig_byte(8'($urandom_range(255)));
    if ($urandom_range(99) < 30) sig_buf[0] = SEQ_TAG;
    flush_sig();
  endtask

  // Write one hash-type register and follow it in the prediction
  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_HT_LOW:  ht_low_cfg  = data;
      CFG_HT_HIGH: ht_high_cfg = data;
      CFG_HT_MASK: ht_mask_cfg = data;
      default: ;
    endcase
  endtask

  // Hold off until every byte is sent and every verdict has come back
  task automatic wait_drained();
    while (byte_q.size() != 0 || sig_if.valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    sig_if.valid     = 1'b0;
    sig_if.sig_byte  = '0;
    sig_if.last_byte = 1'b0;
    res_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: minimal canonical, R length zero, lone final bytes
    sig_buf = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01, 8'h01};
    flush_sig();
    sig_buf = '{8'h30, 8'h06, 8'h02, 8'h00, 8'h02, 8'h02, 8'h01, 8'h01, 8'h01};
    flush_sig();
    sig_buf = '{8'hFF};
    flush_sig();
    sig_buf = '{8'h00};
    flush_sig();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_cfg(CFG_HT_LOW,  PH_LOW[ph]);
      write_cfg(CFG_HT_HIGH, PH_HIGH[ph]);
      write_cfg(CFG_HT_MASK, PH_MASK[ph]);
      cfg_we_i <= 1'b0;
      // Sender light and receiver heavy, then swapped, then no idling
      if (ph < 2) begin
        send_idle_pct <= 17;
        recv_idle_pct <= 52;
      end else if (ph < 4) begin
        send_idle_pct <= 52;
        recv_idle_pct <= 17;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      queued_bytes = 0;
      while (queued_bytes < PHASE_BYTES) begin
        if ($urandom_range(99) < 75) make_wellformed();
        else make_noise();
      end
    end

    while (byte_q.size() != 0 || sig_if.valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dsc_pkg.sv
rtl/dsc_if.sv
rtl/dsc_front.sv
rtl/dsc_queue.sv
rtl/dsc_back.sv
rtl/der_signature_canonical_check.sv
verif/tb_top.sv
